### src/ssd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg - shared types, constants and segment tables
// Segment and digit-select codes for a four-digit active-low display,
// the frame type passed between the front end and the serialiser.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int FRAME_BITS    = 2 * BITS_PER_BYTE;
   localparam int FRAME_CNT_W   = $clog2(FRAME_BITS);
   localparam int NUM_DIGITS    = 4;
   localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);
   localparam int BIN_W         = 14;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;

   localparam logic [14:0] NUMBER_MAX = 15'd9999;

   localparam logic [7:0] BLANK_SEGS   = 8'hFF;
   localparam logic [7:0] POINT_SEGS   = 8'b0111_1111;
   localparam logic [7:0] POINT_SELECT = 8'hF2;

   // Input modes
   localparam logic [1:0] MODE_NUMBER = 2'd0;
   localparam logic [1:0] MODE_DIGIT  = 2'd1;
   localparam logic [1:0] MODE_LETTER = 2'd2;
   localparam logic [1:0] MODE_POINT  = 2'd3;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_EMIT
   } front_state_type;

   // One frame: segment byte then select byte, plus end-of-item mark
   typedef struct packed {
      logic [FRAME_BITS-1:0] bits;
      logic                  last;
   } frame_type;

   // Segment byte for a decimal digit; codes above nine are blank
   function automatic logic [7:0] seg_for_digit(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'hC0;
         4'd1: s = 8'hF9;
         4'd2: s = 8'hA4;
         4'd3: s = 8'hB0;
         4'd4: s = 8'h99;
         4'd5: s = 8'h92;
         4'd6: s = 8'h82;
         4'd7: s = 8'hF8;
         4'd8: s = 8'h80;
         4'd9: s = 8'h90;
         default: s = BLANK_SEGS;
      endcase
      return s;
   endfunction

   // Digit-select byte for a position, leftmost first
   function automatic logic [7:0] pos_select(input logic [1:0] p);
      logic [7:0] s;
      case (p)
         2'd0: s = 8'hF1;
         2'd1: s = 8'hF2;
         2'd2: s = 8'hF4;
         2'd3: s = 8'hF8;
         default: s = 8'hF1;
      endcase
      return s;
   endfunction

   // Segment byte for a character: case folded, non-letters blank
   function automatic logic [7:0] letter_seg(input logic [7:0] ch);
      logic [7:0] up;
      logic [7:0] s;
      up = ch;
      if (ch >= 8'h61 && ch <= 8'h7A) begin
         up = ch - 8'h20;
      end
      case (up)
         8'h41: s = 8'h88;
         8'h42: s = 8'h83;
         8'h43: s = 8'hC6;
         8'h44: s = 8'hA1;
         8'h45: s = 8'h86;
         8'h46: s = 8'h8E;
         8'h47: s = 8'hC2;
         8'h48: s = 8'h89;
         8'h49: s = 8'hCF;
         8'h4A: s = 8'hE1;
         8'h4B: s = 8'h8A;
         8'h4C: s = 8'hC7;
         8'h4D: s = 8'hEA;
         8'h4E: s = 8'hC8;
         8'h4F: s = 8'hC0;
         8'h50: s = 8'h8C;
         8'h51: s = 8'h4A;
         8'h52: s = 8'hCC;
         8'h53: s = 8'h92;
         8'h54: s = 8'h87;
         8'h55: s = 8'hC1;
         8'h56: s = 8'hC1;
         8'h57: s = 8'hD5;
         8'h58: s = 8'h89;
         8'h59: s = 8'h91;
         8'h5A: s = 8'hA4;
         default: s = BLANK_SEGS;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

### src/seven_segment_serial_driver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_serial_driver - serial driver for a four-digit display
// Turns display requests into bit streams for two chained shift registers.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: drive req_* fields and raise req_push; the beat is taken
//   when req_full is low. Mode 0 shows a number 0..9999 (four frames; out
//   of range gives nothing), mode 1 a digit, mode 2 a letter, mode 3 the
//   decimal point of digit 1 (one frame each).
//   Response side: while rsp_empty is low, rsp_serial_bit is the next bit
//   to shift; rsp_frame_end marks the 16th bit of a frame (pulse the latch
//   after it), rsp_last the final bit of the request. rsp_pop takes it.
//   Path: a single-frame request is written into the frame queue and then
//   loaded into the serialiser; a number first enters the digit-split state.
//   Throughput: one bit per cycle from the serialiser while rsp_pop is
//   high. A number holds req_full high while it is split into digits;
//   a 4-frame queue lets the next request be decoded while the current
//   one is still shifting.
//   Stalls: holding rsp_pop low freezes the bit on the ports; the queue
//   then fills and req_full rises. Reset empties the queue and serialiser.
// ----------------------------------------------------------------------------
module seven_segment_serial_driver (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   output logic               req_full,
   input  wire  [1:0]         req_mode,
   input  wire  signed [15:0] req_number,
   input  wire  [1:0]         req_position,
   input  wire  [3:0]         req_digit_value,
   input  wire  [7:0]         req_char_code,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output logic               rsp_serial_bit,
   output logic               rsp_frame_end,
   output logic               rsp_last
);

   ssd_pkg::frame_type push_frame;
   ssd_pkg::frame_type pop_frame;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_nonempty;

   ssd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_number      (req_number),
      .req_position    (req_position),
      .req_digit_value (req_digit_value),
      .req_char_code   (req_char_code),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_frame         (push_frame)
   );

   ssd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .din      (push_frame),
      .full     (q_full),
      .pop      (q_pop),
      .dout     (pop_frame),
      .nonempty (q_nonempty)
   );

   ssd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_nonempty     (q_nonempty),
      .q_frame        (pop_frame),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

### src/ssd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_front - item decode and frame builder
// Accepts items, classifies them by mode and pushes finished frames into
// the frame queue. Numbers are split into digits by compare and subtract,
// one digit per frame, thousands first.
// ----------------------------------------------------------------------------
module ssd_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  wire  [1:0]           req_mode,
   input  wire  signed [15:0]   req_number,
   input  wire  [1:0]           req_position,
   input  wire  [3:0]           req_digit_value,
   input  wire  [7:0]           req_char_code,
   input  wire                  q_full,
   output logic                 q_push,
   output ssd_pkg::frame_type   q_frame
);

   ssd_pkg::front_state_type state_ff, state_in;
   logic [ssd_pkg::BIN_W-1:0]       rem_ff, rem_in;
   logic [ssd_pkg::DIGIT_IDX_W-1:0] idx_ff, idx_in;

   logic                            accept;
   logic                            in_range;
   logic [ssd_pkg::BIN_W-1:0]       weight;
   logic [ssd_pkg::BIN_W-1:0]       cur_sub;
   logic [3:0]                      cur_digit;
   logic [7:0]                      single_segs;
   logic [7:0]                      single_sel;

   // Beat taken only from idle, and only while the queue has room
   assign req_full = (state_ff != ssd_pkg::FRONT_IDLE) || q_full;
   assign accept   = req_push && !req_full;
   assign in_range = !req_number[15] && (req_number[14:0] <= ssd_pkg::NUMBER_MAX);

   // Decimal weight of the digit being emitted
   always_comb begin
      case (idx_ff)
         2'd0: weight = ssd_pkg::BIN_W'(1000);
         2'd1: weight = ssd_pkg::BIN_W'(100);
         2'd2: weight = ssd_pkg::BIN_W'(10);
         2'd3: weight = ssd_pkg::BIN_W'(1);
         default: weight = ssd_pkg::BIN_W'(1);
      endcase
   end

   // Digit = number of whole weights that fit in the remainder
   always_comb begin
      cur_digit = '0;
      cur_sub   = '0;
      for (int k = 1; k <= 9; k++) begin
         if (rem_ff >= ssd_pkg::BIN_W'(k) * weight) begin
            cur_digit = 4'(k);
            cur_sub   = ssd_pkg::BIN_W'(k) * weight;
         end
      end
   end

   // Single-frame modes
   always_comb begin
      case (req_mode)
         ssd_pkg::MODE_DIGIT: begin
            single_segs = ssd_pkg::seg_for_digit(req_digit_value);
            single_sel  = ssd_pkg::pos_select(req_position);
         end
         ssd_pkg::MODE_LETTER: begin
            single_segs = ssd_pkg::letter_seg(req_char_code);
            single_sel  = ssd_pkg::pos_select(req_position);
         end
         default: begin
            single_segs = ssd_pkg::POINT_SEGS;
            single_sel  = ssd_pkg::POINT_SELECT;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssd_pkg::FRONT_IDLE: begin
            if (accept && req_mode == ssd_pkg::MODE_NUMBER && in_range) begin
               state_in = ssd_pkg::FRONT_EMIT;
            end
         end
         ssd_pkg::FRONT_EMIT: begin
            if (!q_full && idx_ff == ssd_pkg::DIGIT_IDX_W'(ssd_pkg::NUM_DIGITS - 1)) begin
               state_in = ssd_pkg::FRONT_IDLE;
            end
         end
         default: state_in = ssd_pkg::FRONT_IDLE;
      endcase
   end

   // Outputs and datapath next values
   always_comb begin
      q_push  = 1'b0;
      q_frame = '0;
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      case (state_ff)
         ssd_pkg::FRONT_IDLE: begin
            q_push       = accept && (req_mode != ssd_pkg::MODE_NUMBER);
            q_frame.bits = {single_segs, single_sel};
            q_frame.last = 1'b1;
            rem_in       = req_number[ssd_pkg::BIN_W-1:0];
            idx_in       = '0;
         end
         ssd_pkg::FRONT_EMIT: begin
            q_push       = !q_full;
            q_frame.bits = {ssd_pkg::seg_for_digit(cur_digit), ssd_pkg::pos_select(idx_ff)};
            q_frame.last = (idx_ff == ssd_pkg::DIGIT_IDX_W'(ssd_pkg::NUM_DIGITS - 1));
            if (!q_full) begin
               rem_in = rem_ff - cur_sub;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssd_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff <= rem_in;
      idx_ff <= idx_in;
   end

   // Remainder stays below ten weights, so every digit is decimal
   a_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssd_pkg::FRONT_EMIT) |-> (rem_ff < ssd_pkg::BIN_W'(10) * weight))
      else $error("ssd_front: remainder too large for digit position");

endmodule
`default_nettype wire

### src/ssd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_fifo - frame queue
// Short queue of frames between the front end and the serialiser.
// ----------------------------------------------------------------------------
module ssd_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ssd_pkg::frame_type   din,
   output logic                 full,
   input  wire                  pop,
   output ssd_pkg::frame_type   dout,
   output logic                 nonempty
);

   ssd_pkg::frame_type               mem_ff [ssd_pkg::QUEUE_DEPTH];
   logic [ssd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full     = (count_ff == ssd_pkg::QUEUE_CNT_W'(ssd_pkg::QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign dout     = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   // Occupancy never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssd_pkg::QUEUE_CNT_W'(ssd_pkg::QUEUE_DEPTH))
      else $error("ssd_fifo: occupancy overflow");

endmodule
`default_nettype wire

### src/ssd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_back - frame serialiser
// Pulls frames from the queue and presents them one bit per beat, MSB of
// the segment byte first, marking the latch bit and the end of each item.
// ----------------------------------------------------------------------------
module ssd_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_nonempty,
   input  ssd_pkg::frame_type   q_frame,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output logic                 rsp_serial_bit,
   output logic                 rsp_frame_end,
   output logic                 rsp_last
);

   logic                            busy_ff, busy_in;
   logic [ssd_pkg::FRAME_BITS-1:0]  shift_ff, shift_in;
   logic [ssd_pkg::FRAME_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            last_ff, last_in;
   logic                            at_end;
   logic                            taken;

   assign at_end = (cnt_ff == ssd_pkg::FRAME_CNT_W'(ssd_pkg::FRAME_BITS - 1));
   assign taken  = busy_ff && rsp_pop;
   assign q_pop  = q_nonempty && (!busy_ff || (taken && at_end));

   // Result ports decoded from registers alone
   assign rsp_empty      = !busy_ff;
   assign rsp_serial_bit = shift_ff[ssd_pkg::FRAME_BITS-1];
   assign rsp_frame_end  = at_end;
   assign rsp_last       = last_ff && at_end;

   // Load a new frame or shift on each taken beat
   always_comb begin
      busy_in  = busy_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         shift_in = q_frame.bits;
         cnt_in   = '0;
         last_in  = q_frame.last;
      end else if (taken) begin
         shift_in = {shift_ff[ssd_pkg::FRAME_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (at_end) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      last_ff  <= last_in;
   end

   // End of item only falls on a latch bit
   a_last_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_frame_end)
      else $error("ssd_back: item end away from frame end");

   // A frame cannot stop part way through
   a_no_mid_frame_stop: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !at_end) |=> busy_ff)
      else $error("ssd_back: frame dropped mid-way");

endmodule
`default_nettype wire
